FILE: hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants shared by the framed command receiver blocks.
// ----------------------------------------------------------------------------
package fcr_pkg;

    // Frame bytes and page rules
    localparam logic [7:0] HEADER_BYTE     = 8'hAA;
    localparam logic [7:0] TAIL_BYTE       = 8'h55;
    localparam logic [9:0] TIMEOUT_RESET   = 10'd500;
    localparam logic [8:0] PAGE_OFFSET     = 9'd5;
    localparam logic [7:0] DIRECT_PAGE_MIN = 8'd1;
    localparam logic [7:0] DIRECT_PAGE_MAX = 8'd4;

    // Item kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    // Output beat
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       is_last;
        logic [8:0] page_value;
    } result_t;

    // Accepted frame passed from front to back
    typedef struct packed {
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [8:0] page;
    } frame_t;

    // Receive position within a frame
    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_DATA0  = 2'd1,
        POS_DATA1  = 2'd2,
        POS_TAIL   = 2'd3
    } frame_pos_t;

    // Echo beat index
    typedef enum logic [1:0] {
        ECHO_HEADER = 2'd0,
        ECHO_FIRST  = 2'd1,
        ECHO_SECOND = 2'd2,
        ECHO_TAIL   = 2'd3
    } echo_idx_t;

endpackage

FILE: hdl/framed_command_receiver_timeout.sv
// ----------------------------------------------------------------------------
// framed_command_receiver_timeout
// Header/tail framed command receiver with idle timeout and frame echo.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  item      item_valid / item_ready      item (kind, rx_byte)
//  result    result_valid / result_ready  result (tx_byte, is_last, page_value)
//  config    cfg_we                       cfg_data (timeout_ticks)
//
//  One item is taken per cycle while item_ready is high; each is handled on accept.
//  A good frame is queued and echoed from the output register as four beats,
//  one per cycle unless result_ready is low; echo sets the sustained burst rate.
//  item_ready drops only while the frame queue is full.
//  Reset clears frame state and the idle counter, and loads timeout 500.
// ----------------------------------------------------------------------------
module framed_command_receiver_timeout
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [9:0]       cfg_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  fcr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output fcr_pkg::result_t result
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            not_empty;
    logic            full;
    fcr_pkg::frame_t wr_frame;
    fcr_pkg::frame_t rd_frame;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    // Front: classification and frame tracking
    fcr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .item     (item),
        .push     (push),
        .frame    (wr_frame)
    );

    // Frame queue
    fcr_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_frame  (wr_frame),
        .pop       (pop),
        .rd_frame  (rd_frame),
        .not_empty (not_empty),
        .full      (full)
    );

    // Back: echo sequencer
    fcr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_avail  (not_empty),
        .frame        (rd_frame),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hdl/fcr_front.sv
// ----------------------------------------------------------------------------
// fcr_front
// Accepts bytes and ticks, tracks the frame and the idle counter, and
// pushes each good frame into the frame queue.
// ----------------------------------------------------------------------------
module fcr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [9:0]      cfg_data,
    input  logic            accept,
    input  fcr_pkg::item_t  item,
    output logic            push,
    output fcr_pkg::frame_t frame
);

    fcr_pkg::frame_pos_t pos_reg, pos_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [9:0] idle_reg, idle_next;
    logic [9:0] timeout_reg;
    logic       timed_out;
    logic       is_byte;
    logic       direct;

    assign timed_out = idle_reg >= timeout_reg;
    assign is_byte   = accept && (item.kind == fcr_pkg::KIND_BYTE);
    assign direct    = (first_reg >= fcr_pkg::DIRECT_PAGE_MIN) &&
                       (first_reg <= fcr_pkg::DIRECT_PAGE_MAX);

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= fcr_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= fcr_pkg::POS_HEADER;
            first_reg  <= '0;
            second_reg <= '0;
            idle_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            idle_reg   <= idle_next;
        end
    end

    // Next frame position
    always_comb
    begin
        pos_next = pos_reg;
        if (is_byte)
        begin
            if (timed_out && (pos_reg != fcr_pkg::POS_HEADER))
            begin
                pos_next = fcr_pkg::POS_HEADER;
            end
            else
            begin
                case (pos_reg)
                    fcr_pkg::POS_HEADER:
                    begin
                        if (item.rx_byte == fcr_pkg::HEADER_BYTE)
                        begin
                            pos_next = fcr_pkg::POS_DATA0;
                        end
                    end
                    fcr_pkg::POS_DATA0: pos_next = fcr_pkg::POS_DATA1;
                    fcr_pkg::POS_DATA1: pos_next = fcr_pkg::POS_TAIL;
                    default:            pos_next = fcr_pkg::POS_HEADER;
                endcase
            end
        end
    end

    // Data capture, idle counter and frame push
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        idle_next   = idle_reg;
        push        = 1'b0;
        frame.first_data  = first_reg;
        frame.second_data = second_reg;
        frame.page        = direct ? {1'b0, first_reg}
                                   : {1'b0, second_reg} + fcr_pkg::PAGE_OFFSET;
        if (accept && (item.kind == fcr_pkg::KIND_TICK))
        begin
            if (idle_reg < timeout_reg)
            begin
                idle_next = idle_reg + 10'd1;
            end
        end
        else if (is_byte)
        begin
            idle_next = '0;
            if (!(timed_out && (pos_reg != fcr_pkg::POS_HEADER)))
            begin
                case (pos_reg)
                    fcr_pkg::POS_DATA0: first_next  = item.rx_byte;
                    fcr_pkg::POS_DATA1: second_next = item.rx_byte;
                    fcr_pkg::POS_TAIL:
                    begin
                        if (item.rx_byte == fcr_pkg::TAIL_BYTE)
                        begin
                            push        = 1'b1;
                            first_next  = '0;
                            second_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: hdl/fcr_queue.sv
// ----------------------------------------------------------------------------
// fcr_queue
// Small register FIFO of accepted frames between front and back.
// ----------------------------------------------------------------------------
module fcr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fcr_pkg::frame_t wr_frame,
    input  logic            pop,
    output fcr_pkg::frame_t rd_frame,
    output logic            not_empty,
    output logic            full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fcr_pkg::frame_t   slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == FULL_CNT;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_frame  = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

FILE: hdl/fcr_back.sv
// ----------------------------------------------------------------------------
// fcr_back
// Echoes each queued frame as four beats through an output register.
// ----------------------------------------------------------------------------
module fcr_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_avail,
    input  fcr_pkg::frame_t  frame,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output fcr_pkg::result_t result
);

    fcr_pkg::echo_idx_t idx_reg, idx_next;
    logic               valid_reg, valid_next;
    fcr_pkg::result_t   beat_reg, beat_next;
    logic               load;

    assign load         = frame_avail && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= fcr_pkg::ECHO_HEADER;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    // Next echo index
    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            case (idx_reg)
                fcr_pkg::ECHO_HEADER: idx_next = fcr_pkg::ECHO_FIRST;
                fcr_pkg::ECHO_FIRST:  idx_next = fcr_pkg::ECHO_SECOND;
                fcr_pkg::ECHO_SECOND: idx_next = fcr_pkg::ECHO_TAIL;
                default:              idx_next = fcr_pkg::ECHO_HEADER;
            endcase
        end
    end

    // Beat contents, valid and queue pop
    always_comb
    begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next           = 1'b1;
            beat_next.page_value = frame.page;
            beat_next.is_last    = 1'b0;
            case (idx_reg)
                fcr_pkg::ECHO_HEADER: beat_next.tx_byte = fcr_pkg::HEADER_BYTE;
                fcr_pkg::ECHO_FIRST:  beat_next.tx_byte = frame.first_data;
                fcr_pkg::ECHO_SECOND: beat_next.tx_byte = frame.second_data;
                default:
                begin
                    beat_next.tx_byte = fcr_pkg::TAIL_BYTE;
                    beat_next.is_last = 1'b1;
                    pop               = 1'b1;
                end
            endcase
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

endmodule
